[hdl/bms_pkg.sv]
// Shared types, register codes and helpers of the 3x3 binary majority smoothing block.
package bms_pkg;

  // Widths of the configuration registers.
  localparam int SIZE_W = 8;
  localparam int THR_W  = 4;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic REG_SIZE   = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  // Reset and limit values of the registers.
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 8'd3;
  localparam logic [SIZE_W-1:0] SIZE_RST   = 8'd100;
  localparam logic [THR_W-1:0]  THRESH_RST = 4'd5;

  // Beat kinds carried on the input tuser bit.
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // Payload widths on the stream ports.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;
  localparam int POS_W      = 7;

  // One shift cell: the original pixel and the smoothed pixel at the same delay.
  typedef struct packed {
    logic orig;
    logic smooth;
  } bms_pair_t;

  // Per-beat decisions of the position controller.
  typedef struct packed {
    logic advance;  // beat is taken into the window and the shift line
    logic emit;     // beat produces a result
    logic inner;    // result pixel is not on the border
    logic last;     // result pixel closes the frame
  } bms_ctl_t;

  // Limit a written image size to the supported range.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] vmax);
    logic [SIZE_W-1:0] res;
    if (v < SIZE_MIN) begin
      res = SIZE_MIN;
    end else if (v > vmax) begin
      res = vmax;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

[hdl/bms_cell.sv]
// One cell of the line delay: holds an original and a smoothed pixel and hands them on.
module bms_cell
  import bms_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  logic      load_head,
  input  bms_pair_t head_d,
  input  bms_pair_t prev_d,
  output bms_pair_t q
);

  bms_pair_t q_r;
  bms_pair_t q_nxt;

  // The cell at the active line length takes the new pixel, the others shift down.
  always_comb begin
    q_nxt = q_r;
    if (en) begin
      q_nxt = load_head ? head_d : prev_d;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

[hdl/bms_ctrl.sv]
// Input and output position counters, frame start and end handling.
module bms_ctrl
  import bms_pkg::*;
#(
  parameter int CNT_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              flush,
  input  logic              restart,
  input  logic [SIZE_W-1:0] size,
  output bms_ctl_t          ctl,
  output logic [CNT_W-1:0]  row,
  output logic [CNT_W-1:0]  col
);

  logic [CNT_W-1:0] in_row_r, in_row_nxt;
  logic [CNT_W-1:0] in_col_r, in_col_nxt;
  logic [CNT_W-1:0] out_row_r, out_row_nxt;
  logic [CNT_W-1:0] out_col_r, out_col_nxt;
  logic [CNT_W-1:0] n_m1;
  logic             ignore;
  logic             emit;
  logic             last;

  assign n_m1 = CNT_W'(size) - CNT_W'(1);

  // A flush before the first pixel of a frame is dropped without effect.
  assign ignore = (in_row_r == '0) && (in_col_r == '0) && flush;

  // Results start one row plus one pixel after the frame starts.
  assign emit = (in_row_r >= CNT_W'(2)) || ((in_row_r == CNT_W'(1)) && (in_col_r != '0));
  assign last = (out_row_r == n_m1) && (out_col_r == n_m1);

  assign ctl.advance = fire && !ignore;
  assign ctl.emit    = emit;
  assign ctl.last    = last;
  assign ctl.inner   = (out_row_r != '0) && (out_row_r < n_m1) &&
                       (out_col_r != '0) && (out_col_r < n_m1);

  // Advance the raster counters; a restart or the final result of a frame clears them all.
  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    if (restart || (ctl.advance && emit && last)) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
    end else if (ctl.advance) begin
      if (in_col_r == n_m1) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + CNT_W'(1);
      end else begin
        in_col_nxt = in_col_r + CNT_W'(1);
      end
      if (emit) begin
        if (out_col_r == n_m1) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + CNT_W'(1);
        end else begin
          out_col_nxt = out_col_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
    end else begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
    end
  end

  assign row = out_row_r;
  assign col = out_col_r;

endmodule

[hdl/bms_vote.sv]
// Counts the ones of the nine window cells and compares against the threshold.
module bms_vote
  import bms_pkg::*;
(
  input  logic [8:0]       cells,
  input  logic [THR_W-1:0] thresh,
  output logic             vote
);

  logic [THR_W-1:0] cnt;

  // Population count of the window.
  always_comb begin
    cnt = '0;
    for (int i = 0; i < 9; i++) begin
      cnt = cnt + THR_W'(cells[i]);
    end
  end

  assign vote = (cnt >= thresh);

endmodule

[hdl/binary_majority_smoothing_3x3_core.sv]
// Top level of the 3x3 binary majority smoothing block: config, line delay, window, output.
//
// Pixels enter in raster order, one beat per clock while out_tready keeps the result
// register free, and results leave at the same rate: each accepted beat updates the
// window and shifts the line delay, and the result register passes on the smoothed
// pixel in the next cycle. The result for pixel (r,c) is produced by the input beat
// image_size+1 beats later, so a frame needs image_size+1 flush beats (tuser set)
// after its last pixel; a flush before the first pixel of a frame is dropped. The
// line delay is a chain of MAX_SIZE+1 shift cells (MAX_SIZE capped at 255 for the
// 8-bit size register), each holding an original and a smoothed pixel, which sets
// the largest image side. Writing image_size restarts the frame; no clearing pass is
// needed after reset. Register map: 0x0 image_size (clamped to 3..capped MAX_SIZE), 0x4 vote_threshold.
module binary_majority_smoothing_3x3_core
  import bms_pkg::*;
#(
  parameter int MAX_SIZE = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] pixel_in, [7:1] zero
  input  logic                  in_tuser,   // [0] action (1 = flush)
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] pixel_out, [7:1] out_row, [14:8] out_col
  output logic                  out_tlast,  // frame_last
  // Configuration port.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int NMAX   = (MAX_SIZE < 255) ? MAX_SIZE : 255;
  localparam int NCELLS = NMAX + 1;
  localparam int CNT_W  = $clog2(NMAX + 2);
  localparam logic [SIZE_W-1:0] SIZE_LIM  = SIZE_W'(NMAX);
  localparam logic [SIZE_W-1:0] SIZE_INIT = (NMAX < 100) ? SIZE_W'(NMAX) : SIZE_RST;

  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [THR_W-1:0]  thresh_r, thresh_nxt;
  logic              cfg_wr;
  logic              restart;
  logic              in_fire;
  logic              flush;
  logic              pix;
  bms_ctl_t          ctl;
  logic [CNT_W-1:0]  row;
  logic [CNT_W-1:0]  col;
  bms_pair_t         head_d;
  bms_pair_t         chain_q [NCELLS];
  logic              d1_r, d1_nxt;
  logic              d2_r, d2_nxt;
  logic              left_r, left_nxt;
  logic [8:0]        cells;
  logic              vote;
  logic              res;
  logic              out_valid_r, out_valid_nxt;
  logic              pix_out_r, pix_out_nxt;
  logic [POS_W-1:0]  row_out_r, row_out_nxt;
  logic [POS_W-1:0]  col_out_r, col_out_nxt;
  logic              last_out_r, last_out_nxt;

  // Configuration writes and readback.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign restart    = cfg_wr && (cfg_paddr[2] == REG_SIZE);

  always_comb begin
    size_nxt   = size_r;
    thresh_nxt = thresh_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SIZE:   size_nxt   = clamp_size(cfg_pwdata[SIZE_W-1:0], SIZE_LIM);
        REG_THRESH: thresh_nxt = cfg_pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_SIZE:   cfg_prdata = {{(32-SIZE_W){1'b0}}, size_r};
      REG_THRESH: cfg_prdata = {{(32-THR_W){1'b0}}, thresh_r};
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= SIZE_INIT;
      thresh_r <= THRESH_RST;
    end else begin
      size_r   <= size_nxt;
      thresh_r <= thresh_nxt;
    end
  end

  // Input handshake; the result register frees itself when the consumer takes it.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign flush     = (in_tuser == ACT_FLUSH);
  assign pix       = in_tdata[0] && !flush;

  bms_ctrl #(
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .flush   (flush),
    .restart (restart),
    .size    (size_r),
    .ctl     (ctl),
    .row     (row),
    .col     (col)
  );

  // Line delay: cell 0 holds the beat image_size+1 back, cell 1 image_size, cell 2 one less.
  assign head_d.orig   = pix;
  assign head_d.smooth = res;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    bms_cell u_cell (
      .clk       (clk),
      .en        (ctl.advance),
      .load_head (size_r == SIZE_W'(i)),
      .head_d    (head_d),
      .prev_d    ((i == NCELLS - 1) ? head_d : chain_q[(i + 1) % NCELLS]),
      .q         (chain_q[i])
    );
  end

  // Window: row above smoothed, left smoothed, current and lower rows original.
  assign cells = {chain_q[0].smooth, chain_q[1].smooth, chain_q[2].smooth, left_r,
                  chain_q[0].orig, chain_q[1].orig, d2_r, d1_r, pix};

  bms_vote u_vote (
    .cells  (cells),
    .thresh (thresh_r),
    .vote   (vote)
  );

  // Border pixels keep their original value.
  assign res = ctl.inner ? vote : chain_q[0].orig;

  // Short delays for the lower row and the left neighbor.
  always_comb begin
    d1_nxt   = d1_r;
    d2_nxt   = d2_r;
    left_nxt = left_r;
    if (ctl.advance) begin
      d1_nxt   = pix;
      d2_nxt   = d1_r;
      left_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    d1_r   <= d1_nxt;
    d2_r   <= d2_nxt;
    left_r <= left_nxt;
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    pix_out_nxt   = pix_out_r;
    row_out_nxt   = row_out_r;
    col_out_nxt   = col_out_r;
    last_out_nxt  = last_out_r;
    if (ctl.advance && ctl.emit) begin
      out_valid_nxt = 1'b1;
      pix_out_nxt   = res;
      row_out_nxt   = POS_W'(row);
      col_out_nxt   = POS_W'(col);
      last_out_nxt  = ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_out_r  <= pix_out_nxt;
    row_out_r  <= row_out_nxt;
    col_out_r  <= col_out_nxt;
    last_out_r <= last_out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, col_out_r, row_out_r, pix_out_r};
  assign out_tlast  = last_out_r;

endmodule

[hdl/bms_checker.sv]
// Port-level checks of the smoothing block's stream behavior, bound to the top level.
module bms_checker
  import bms_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // A waiting result beat holds its contents until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // The input side is open whenever the result register is empty or being drained.
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled although the result register is free");

  // A new result beat only follows an accepted input beat.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tvalid && in_tready) && !(out_tvalid && !out_tready) |=> !out_tvalid)
    else $error("result beat without an accepted input beat");

  // The frame closes on the bottom right corner, where row and column agree.
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[7:1] == out_tdata[14:8])
    else $error("frame end flagged away from the corner pixel");

endmodule

bind binary_majority_smoothing_3x3_core bms_checker u_bms_checker (.*);
